### sv/rhsv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_pkg: shared types and constants
// beat formats, register indexes and hash constants for the hash/sign/verify block
// ----------------------------------------------------------------------------
package rhsv_pkg;

  localparam int DATA_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int HASH_W      = 30;
  localparam int HASH_WORK_W = 35;
  localparam int HASH_STEPS  = 5;
  localparam int STEP_W      = 3;
  localparam int CFG_IDX_W   = 2;

  localparam logic [HASH_W-1:0]      HASH_PRIME = 30'd1000000007;
  localparam logic [HASH_WORK_W-1:0] HASH_MULT  = 35'd31;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_EXPONENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERIFY_MODE  = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] message_byte;
    logic              last_byte;
    logic [DATA_W-1:0] claimed_signature;
  } msg_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              signature_valid;
  } res_t;

  typedef struct packed {
    logic              start;
    logic              clear;
    logic [BYTE_W-1:0] data_byte;
  } hash_ctl_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] base;
  } mx_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] value;
  } mx_rsp_t;

  // multiple of the prime removed at each reduction step
  function automatic logic [HASH_WORK_W-1:0] hash_sub(input logic [STEP_W-1:0] step);
    logic [HASH_WORK_W-1:0] p;
    p = HASH_WORK_W'(HASH_PRIME);
    case (step)
      3'd0:    hash_sub = p << 4;
      3'd1:    hash_sub = p << 3;
      3'd2:    hash_sub = p << 2;
      3'd3:    hash_sub = p << 1;
      default: hash_sub = p;
    endcase
  endfunction

endpackage
`default_nettype wire

### sv/rhsv_addmod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_addmod: shared modular adder
// y = (a + b) mod m for a, b below m
// ----------------------------------------------------------------------------
module rhsv_addmod #(
  parameter int W = 32
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic [W-1:0] m,
  output logic      [W-1:0] y
);

  logic [W:0] sum;
  logic [W:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = sum - {1'b0, m};
  assign y    = (sum >= {1'b0, m}) ? diff[W-1:0] : sum[W-1:0];

endmodule
`default_nettype wire

### sv/rhsv_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_hash: running polynomial hash
// hash = (hash*31 + byte) mod prime, reduced by one compare-subtract per cycle
// ----------------------------------------------------------------------------
module rhsv_hash
  import rhsv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hash_ctl_t         ctl,
  output logic                   done,
  output logic      [HASH_W-1:0] hash
);

  logic [HASH_W-1:0]      running_hash;
  logic [HASH_WORK_W-1:0] work;
  logic [STEP_W-1:0]      step;
  logic                   busy;
  logic [HASH_WORK_W-1:0] sub;
  logic [HASH_WORK_W-1:0] work_next;

  assign sub       = hash_sub(step);
  assign work_next = (work >= sub) ? (work - sub) : work;
  assign hash      = running_hash;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      busy         <= 1'b0;
      done         <= 1'b0;
      step         <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.clear) begin
        running_hash <= '0;
      end
      if (ctl.start) begin
        work <= HASH_WORK_W'(running_hash) * HASH_MULT + HASH_WORK_W'(ctl.data_byte);
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        work <= work_next;
        step <= step + 1'b1;
        if (step == STEP_W'(HASH_STEPS - 1)) begin
          running_hash <= work_next[HASH_W-1:0];
          busy         <= 1'b0;
          done         <= 1'b1;
        end
      end
    end
  end

  a_hash_below_prime: assert property (@(posedge clk) disable iff (rst)
    running_hash < HASH_PRIME) else $error("hash not reduced");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("hash done while busy");

endmodule
`default_nettype wire

### sv/rhsv_modexp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhsv_modexp: modular exponentiation sequencer
// base reduction, square-and-multiply and shift-add multiply on one modular adder
// ----------------------------------------------------------------------------
module rhsv_modexp
  import rhsv_pkg::*;
#(
  parameter int OPW = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mx_req_t        req,
  input  wire logic [OPW-1:0] exponent,
  input  wire logic [OPW-1:0] modulus,
  output mx_rsp_t             rsp
);

  localparam int CNT_W = $clog2(DATA_W + 1);
  localparam logic [OPW-1:0] ONE = OPW'(1);
  localparam logic [OPW-1:0] TWO = OPW'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED_DBL,
    S_RED_INC,
    S_EXP_CHK,
    S_MUL_ADD,
    S_MUL_DBL
  } state_t;

  state_t            state;
  logic [OPW-1:0]    mod_r;
  logic [OPW-1:0]    ex;
  logic [DATA_W-1:0] src;
  logic [CNT_W-1:0]  cnt;
  logic [OPW-1:0]    acc;
  logic [OPW-1:0]    pbase;
  logic [OPW-1:0]    ma;
  logic [OPW-1:0]    mb;
  logic [OPW-1:0]    mp;
  logic              sq;
  logic [OPW-1:0]    ua;
  logic [OPW-1:0]    ub;
  logic [OPW-1:0]    usum;
  logic [OPW-1:0]    red_next;

  always_comb begin
    case (state)
      S_RED_DBL: begin
        ua = acc;
        ub = acc;
      end
      S_RED_INC: begin
        ua = acc;
        ub = ONE;
      end
      S_MUL_ADD: begin
        ua = mb[0] ? mp : ma;
        ub = ma;
      end
      S_MUL_DBL: begin
        ua = ma;
        ub = ma;
      end
      default: begin
        ua = acc;
        ub = acc;
      end
    endcase
  end

  rhsv_addmod #(.W(OPW)) u_addmod (
    .a(ua),
    .b(ub),
    .m(mod_r),
    .y(usum)
  );

  assign red_next = src[DATA_W-1] ? usum : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            mod_r <= modulus;
            ex    <= exponent;
            src   <= req.base;
            cnt   <= CNT_W'(DATA_W);
            acc   <= '0;
            if (modulus < TWO) begin
              rsp.value <= '0;
              rsp.done  <= 1'b1;
            end else begin
              state <= S_RED_DBL;
            end
          end
        end
        S_RED_DBL: begin
          acc   <= usum;
          state <= S_RED_INC;
        end
        S_RED_INC: begin
          src <= src << 1;
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            pbase <= red_next;
            acc   <= ONE;
            state <= S_EXP_CHK;
          end else begin
            acc   <= red_next;
            state <= S_RED_DBL;
          end
        end
        S_EXP_CHK: begin
          mp <= '0;
          if (ex == '0) begin
            rsp.value <= DATA_W'(acc);
            rsp.done  <= 1'b1;
            state     <= S_IDLE;
          end else if (ex[0]) begin
            ma    <= acc;
            mb    <= pbase;
            sq    <= 1'b0;
            state <= S_MUL_ADD;
          end else begin
            ma    <= pbase;
            mb    <= pbase;
            sq    <= 1'b1;
            state <= S_MUL_ADD;
          end
        end
        S_MUL_ADD: begin
          if (mb == '0) begin
            if (!sq) begin
              acc <= mp;
              ma  <= pbase;
              mb  <= pbase;
              mp  <= '0;
              sq  <= 1'b1;
            end else begin
              pbase <= mp;
              ex    <= ex >> 1;
              state <= S_EXP_CHK;
            end
          end else if (mb[0]) begin
            mp    <= usum;
            state <= S_MUL_DBL;
          end else begin
            ma <= usum;
            mb <= mb >> 1;
          end
        end
        S_MUL_DBL: begin
          ma    <= usum;
          mb    <= mb >> 1;
          state <= S_MUL_ADD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_operands_reduced: assert property (@(posedge clk) disable iff (rst)
    state == S_EXP_CHK |-> (acc < mod_r) && (pbase < mod_r))
    else $error("exponent operands not reduced");

  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (rsp.value < DATA_W'(mod_r)) || (rsp.value == '0))
    else $error("result not below modulus");

endmodule
`default_nettype wire

### sv/rsa_hash_sign_verify.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_hash_sign_verify: message hash with sign or verify
// byte-wise polynomial hash, then modular exponentiation on the last byte
// ----------------------------------------------------------------------------
// Each message beat updates hash = (hash*31 + byte) mod 1000000007; the block
// accepts no new byte until the five compare-subtract steps of the hash
// reduction are through. On the last byte the block raises hash (sign) or the
// claimed signature (verify) to key_exponent mod modulus on one shared modular
// adder: a double-and-add pass over the base bits first reduces the base, then
// each exponent bit costs one squaring plus, for a set bit, one multiply, each
// multiply a shift-add pass over the multiplier bits. A result beat waits in an
// output register; the block takes bytes again once the result has moved into
// that register, which happens as soon as the previous result beat has left.
// Configuration is written through the cfg channel while the block is idle.
// ----------------------------------------------------------------------------
module rsa_hash_sign_verify
  import rhsv_pkg::*;
#(
  parameter int MODULUS_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 msg_valid,
  output logic                      msg_ready,
  input  wire msg_t                 msg,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output res_t                      res,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  localparam int OPW = (MODULUS_BITS < DATA_W) ? MODULUS_BITS : DATA_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_EXP,
    S_PUT
  } state_t;

  state_t            state;
  logic [OPW-1:0]    modulus;
  logic [OPW-1:0]    key_exponent;
  logic              verify_mode;
  logic              last_r;
  logic [DATA_W-1:0] sig_r;
  logic [HASH_W-1:0] msg_hash;
  res_t              res_r;
  hash_ctl_t         hctl;
  logic              hash_done;
  logic [HASH_W-1:0] hash;
  mx_req_t           mreq;
  mx_rsp_t           mrsp;

  assign msg_ready = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !msg_valid;

  assign hctl.start     = (state == S_IDLE) && msg_valid;
  assign hctl.clear     = (state == S_HASH) && hash_done && last_r;
  assign hctl.data_byte = msg.message_byte;

  assign mreq.start = hctl.clear;
  assign mreq.base  = verify_mode ? DATA_W'(sig_r[OPW-1:0]) : DATA_W'(hash);

  rhsv_hash u_hash (
    .clk (clk),
    .rst (rst),
    .ctl (hctl),
    .done(hash_done),
    .hash(hash)
  );

  rhsv_modexp #(.OPW(OPW)) u_modexp (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .exponent(key_exponent),
    .modulus (modulus),
    .rsp     (mrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      res_valid    <= 1'b0;
      modulus      <= OPW'(3);
      key_exponent <= OPW'(1);
      verify_mode  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODULUS:      modulus      <= cfg_data[OPW-1:0];
          REG_KEY_EXPONENT: key_exponent <= cfg_data[OPW-1:0];
          REG_VERIFY_MODE:  verify_mode  <= cfg_data[0];
          default: ;
        endcase
      end
      if (res_valid && res_ready && (state != S_PUT)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (msg_valid) begin
            last_r <= msg.last_byte;
            sig_r  <= msg.claimed_signature;
            state  <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            msg_hash <= hash;
            state    <= last_r ? S_EXP : S_IDLE;
          end
        end
        S_EXP: begin
          if (mrsp.done) begin
            res_r.result_value    <= mrsp.value;
            res_r.signature_valid <= verify_mode && (mrsp.value == DATA_W'(msg_hash));
            state                 <= S_PUT;
          end
        end
        S_PUT: begin
          if (!res_valid || res_ready) begin
            res       <= res_r;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_exp_done_in_exp: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |-> state == S_EXP) else $error("exponent result out of sequence");

  a_hash_done_in_hash: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> state == S_HASH) else $error("hash result out of sequence");

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for rsa_hash_sign_verify
// drives message bytes with random gaps, predicts each signature or verify
// result from a running hash and modular exponentiation, and compares every
// result beat field by field; covers reset keys, field extremes, degenerate
// moduli and exponents, a matched key pair, random keys and backpressure
// ----------------------------------------------------------------------------
module tb;
  import rhsv_pkg::*;

  localparam int STALL_LIMIT   = 50000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 1500;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam longint    RSA_P    = 65521;
  localparam longint    RSA_Q    = 65537;
  localparam longint    RSA_PHI  = (RSA_P - 1) * (RSA_Q - 1);
  localparam logic [31:0] RSA_N  = 32'd4294049777;
  localparam logic [31:0] PUB_EXP = 32'd65537;

  typedef logic [BYTE_W-1:0] byte_q_t[$];
  typedef enum int {SIG_RANDOM, SIG_HASH, SIG_SIGNED, SIG_ZERO, SIG_ONES} sig_kind_e;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              msg_valid = 1'b0;
  logic              msg_ready;
  msg_t              msg       = '0;
  logic              res_valid;
  logic              res_ready = 1'b0;
  res_t              res;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data  = '0;

  // predictor state
  logic [DATA_W-1:0] key_mod   = 32'd3;
  logic [DATA_W-1:0] key_exp   = 32'd1;
  logic              verify_on = 1'b0;
  logic [HASH_W-1:0] run_hash  = '0;
  logic [DATA_W-1:0] priv_exp  = 32'd1;
  res_t              pending_sigs[$];

  int mismatches    = 0;
  int idle_cycles   = 0;
  bit idle_on       = 1'b1;
  int rx_hold_req   = 0;
  int rx_hold_seen  = 0;
  int rx_hold_left  = 0;
  int rx_stall_left = 0;

  rsa_hash_sign_verify u_top (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 1;
    if (r < 85) return $urandom_range(2, 6);
    return $urandom_range(7, 24);
  endfunction

  function automatic logic [HASH_W-1:0] next_hash(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
    logic [63:0] acc;
    acc = (64'(h) * 64'(HASH_MULT) + 64'(b)) % 64'(HASH_PRIME);
    return acc[HASH_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] mod_pow(input logic [DATA_W-1:0] b,
                                                input logic [DATA_W-1:0] e,
                                                input logic [DATA_W-1:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [DATA_W-1:0] k;
    if (m < 32'd2) return '0;
    sq  = 64'(b) % 64'(m);
    acc = 64'd1;
    k   = e;
    while (k != 0) begin
      if (k[0]) acc = (acc * sq) % 64'(m);
      sq = (sq * sq) % 64'(m);
      k  = k >> 1;
    end
    return acc[DATA_W-1:0];
  endfunction

  function automatic void hash_and_sign(input msg_t beat);
    res_t want;
    logic [HASH_W-1:0] msg_hash;
    run_hash = next_hash(run_hash, beat.message_byte);
    if (beat.last_byte) begin
      msg_hash = run_hash;
      run_hash = '0;
      if (verify_on) begin
        want.result_value    = mod_pow(beat.claimed_signature, key_exp, key_mod);
        want.signature_valid = (want.result_value == {2'b00, msg_hash});
      end else begin
        want.result_value    = mod_pow({2'b00, msg_hash}, key_exp, key_mod);
        want.signature_valid = 1'b0;
      end
      pending_sigs.push_back(want);
    end
  endfunction

  function automatic void check_result(input res_t got);
    res_t want;
    if (pending_sigs.size() == 0) begin
      $error("result beat with no signature pending: result_value %0h", got.result_value);
      mismatches++;
      return;
    end
    want = pending_sigs.pop_front();
    if (got.result_value !== want.result_value) begin
      $error("result_value: expected %0h, actual %0h", want.result_value, got.result_value);
      mismatches++;
    end
    if (got.signature_valid !== want.signature_valid) begin
      $error("signature_valid: expected %0b, actual %0b",
             want.signature_valid, got.signature_valid);
      mismatches++;
    end
  endfunction

  // result side: checks beats, random stalls, long hold on request
  always @(posedge clk) begin : result_sink
    int gap;
    if (res_valid && res_ready) check_result(res);
    if (rx_hold_seen != rx_hold_req) begin
      rx_hold_seen <= rx_hold_req;
      rx_hold_left <= HOLD_CYCLES;
      res_ready    <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      res_ready    <= (rx_hold_left == 1);
    end else if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      res_ready     <= (rx_stall_left == 1);
    end else begin
      gap = pick_gap();
      rx_stall_left <= gap;
      res_ready     <= (gap == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (msg_valid && msg_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input msg_t beat);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg       <= beat;
    @(posedge clk);
    while (!msg_ready) @(posedge clk);
    hash_and_sign(beat);
  endtask

  task automatic send_message(input byte_q_t data_q, input sig_kind_e kind);
    logic [HASH_W-1:0] h;
    logic [DATA_W-1:0] sig;
    msg_t beat;
    h = '0;
    foreach (data_q[i]) h = next_hash(h, data_q[i]);
    case (kind)
      SIG_HASH:   sig = {2'b00, h};
      SIG_SIGNED: sig = mod_pow({2'b00, h}, priv_exp, key_mod);
      SIG_ZERO:   sig = '0;
      SIG_ONES:   sig = '1;
      default:    sig = $urandom;
    endcase
    foreach (data_q[i]) begin
      beat.message_byte      = data_q[i];
      beat.last_byte         = (i == data_q.size() - 1);
      beat.claimed_signature = beat.last_byte ? sig : 32'($urandom);
      send_byte(beat);
    end
  endtask

  task automatic send_random_message(input int len, input sig_kind_e kind);
    byte_q_t data_q;
    repeat (len) data_q.push_back(8'($urandom));
    send_message(data_q, kind);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    repeat (pick_gap()) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MODULUS:      key_mod   = data;
      REG_KEY_EXPONENT: key_exp   = data;
      REG_VERIFY_MODE:  verify_on = data[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    msg_valid <= 1'b0;
    while (pending_sigs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // modulus 3, exponent 1, sign: hash is reduced before use
  task automatic test_reset_keys();
    send_message('{8'hFF}, SIG_RANDOM);
    send_message('{8'h00}, SIG_RANDOM);
    send_message('{8'h80, 8'h7F}, SIG_RANDOM);
  endtask

  task automatic test_field_extremes();
    wait_idle();
    write_reg(REG_MODULUS, 32'hFFFF_FFFF);
    write_reg(REG_KEY_EXPONENT, 32'd1);
    // long run of 0xff wraps the hash past the prime
    send_message('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, SIG_RANDOM);
    wait_idle();
    write_reg(REG_KEY_EXPONENT, 32'hFFFF_FFFF);
    send_message('{8'h01}, SIG_RANDOM);
    send_message('{8'hFE}, SIG_RANDOM);
  endtask

  task automatic test_special_keys();
    wait_idle();
    write_reg(REG_KEY_EXPONENT, 32'd0);
    send_message('{8'h12}, SIG_RANDOM);
    wait_idle();
    write_reg(REG_MODULUS, 32'd1);
    send_message('{8'h34}, SIG_RANDOM);
    wait_idle();
    write_reg(REG_MODULUS, 32'd0);
    write_reg(REG_KEY_EXPONENT, 32'd5);
    send_message('{8'h56}, SIG_RANDOM);
    wait_idle();
    write_reg(REG_VERIFY_MODE, 32'hFFFF_FFFF);
    // zero modulus: flag set only for a zero hash
    send_message('{8'h00}, SIG_ONES);
    send_message('{8'h01}, SIG_ZERO);
    wait_idle();
    write_reg(REG_MODULUS, 32'hFFFF_FFFF);
    write_reg(REG_KEY_EXPONENT, 32'd1);
    send_message('{8'h41, 8'h42}, SIG_HASH);
    send_message('{8'h43}, SIG_ONES);
    wait_idle();
    // modulus below the hash can never verify
    write_reg(REG_MODULUS, 32'd1000);
    send_message('{8'h44, 8'h45}, SIG_HASH);
    wait_idle();
    write_reg(REG_SPARE, 32'h1234_5678);
    write_reg(REG_MODULUS, 32'd2);
    write_reg(REG_VERIFY_MODE, 32'hFFFF_FFFE);
    send_message('{8'h07, 8'h09}, SIG_RANDOM);
  endtask

  task automatic test_rsa_pair();
    longint rem_a, rem_b, coef_a, coef_b, quot, tmp;
    sig_kind_e kind;
    wait_idle();
    // private exponent: inverse of the public one mod phi
    rem_a  = RSA_PHI;
    rem_b  = longint'(PUB_EXP);
    coef_a = 0;
    coef_b = 1;
    while (rem_b != 0) begin
      quot   = rem_a / rem_b;
      tmp    = coef_a - quot * coef_b;
      coef_a = coef_b;
      coef_b = tmp;
      tmp    = rem_a - quot * rem_b;
      rem_a  = rem_b;
      rem_b  = tmp;
    end
    if (coef_a < 0) coef_a += RSA_PHI;
    priv_exp = coef_a[31:0];
    write_reg(REG_MODULUS, RSA_N);
    write_reg(REG_KEY_EXPONENT, priv_exp);
    write_reg(REG_VERIFY_MODE, 32'd0);
    repeat (12) send_random_message(rand_len(), SIG_RANDOM);
    wait_idle();
    write_reg(REG_KEY_EXPONENT, PUB_EXP);
    write_reg(REG_VERIFY_MODE, 32'd1);
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) kind = SIG_RANDOM;
      else kind = SIG_SIGNED;
      send_random_message(rand_len(), kind);
    end
  endtask

  task automatic test_random_keys();
    logic [DATA_W-1:0] mod_val, exp_val;
    int pick;
    sig_kind_e kind;
    repeat (12) begin
      wait_idle();
      pick = $urandom_range(0, 9);
      if (pick == 0) mod_val = $urandom_range(0, 4);
      else if (pick < 3) mod_val = $urandom_range(5, 255);
      else mod_val = $urandom;
      pick = $urandom_range(0, 9);
      if (pick == 0) exp_val = '0;
      else if (pick < 3) exp_val = 32'd1;
      else if (pick == 3) exp_val = $urandom | 32'h8000_0000;
      else exp_val = $urandom & ((32'd1 << $urandom_range(2, 20)) - 32'd1);
      write_reg(REG_MODULUS, mod_val);
      write_reg(REG_KEY_EXPONENT, exp_val);
      write_reg(REG_VERIFY_MODE, $urandom);
      repeat (12) begin
        if ($urandom_range(0, 4) < 2) kind = SIG_HASH;
        else kind = SIG_RANDOM;
        send_random_message(rand_len(), kind);
      end
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_reg(REG_MODULUS, $urandom | 32'h8000_0000);
    write_reg(REG_KEY_EXPONENT, 32'd3);
    write_reg(REG_VERIFY_MODE, 32'd0);
    // receiver holds off while single-byte messages keep coming
    rx_hold_req <= rx_hold_req + 1;
    repeat (20) send_random_message(1, SIG_RANDOM);
    wait_idle();
    idle_on = 1'b0;
    repeat (15) send_random_message(rand_len(), SIG_RANDOM);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_keys();
    test_field_extremes();
    test_special_keys();
    test_rsa_pair();
    test_random_keys();
    test_backpressure();
    wait_idle();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
sv/rhsv_pkg.sv
sv/rhsv_addmod.sv
sv/rhsv_hash.sv
sv/rhsv_modexp.sv
sv/rsa_hash_sign_verify.sv
sim/tb.sv
